/* rtl/bmpu_pkg.sv */
`timescale 1ns / 1ps

package bmpu_pkg;

    // Default row alignment of palette rows, in bytes
    localparam int ROW_ALIGN_DEF = 4;

    // Record header codes
    localparam logic [7:0] OBJ_ID       = 8'd20;
    localparam logic [7:0] TYPE_PLAIN   = 8'd1;
    localparam logic [7:0] TYPE_PALETTE = 8'd2;
    localparam logic [7:0] TYPE_RGB565  = 8'd4;

    // Field widths
    localparam int COORD_W = 17;
    localparam int VALUE_W = 16;
    localparam int DATA_W  = 8;
    // Output tdata: x, y, value packed and filled up to whole bytes
    localparam int OUT_TDATA_W = ((2 * COORD_W + VALUE_W + 7) / 8) * 8;

    // Result kind codes
    typedef enum logic [1:0] {
        KIND_PIXEL    = 2'd0,
        KIND_REJECT   = 2'd1,
        KIND_NO_PIXEL = 2'd2
    } t_kind;

    // One input byte of the record
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              record_start;
    } t_item;

    // One result item
    typedef struct packed {
        t_kind              kind;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [VALUE_W-1:0] pixel_value;
        logic               is_rgb565;
        logic               last_pixel;
    } t_result;

endpackage

/* rtl/bitmap_record_pixel_unpacker_top.sv */
`timescale 1ns / 1ps

// Bitmap record pixel unpacker. Takes a record one byte per transfer (tuser
// marks the object id byte of a new record), parses the header (id 20, type,
// then little-endian 16-bit left, top, width, height) and emits one pixel
// write per pixel, bottom row first, left to right. Type 2 gives palette
// indices with rows padded to ROW_ALIGN bytes; type 4 gives RGB565 words.
// Rejected records and records without pixels give one status result.
// Throughput is one byte per clock while the result register is free; a byte
// passes the input register, then the decoder into the result register. The
// user writes display_mode through i_cfg_we / i_cfg_wdata only while idle; the block does not enforce it.
module bitmap_record_pixel_unpacker_top #(
    parameter int ROW_ALIGN = bmpu_pkg::ROW_ALIGN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] record_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [bmpu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
                                        // [16:0] pixel_x, [33:17] pixel_y,
                                        // [49:34] pixel_value, rest zero
    output logic [2:0]  m_axis_tuser,   // [1:0] kind, [2] is_rgb565
    output logic        m_axis_tlast    // last_pixel
);

    localparam int CW = bmpu_pkg::COORD_W;
    localparam int VW = bmpu_pkg::VALUE_W;

    logic              r_display_mode;
    bmpu_pkg::t_item   w_in_item;
    bmpu_pkg::t_item   w_st_item;
    logic              w_st_valid;
    logic              w_out_free;
    logic              w_fire;
    logic              w_res_valid;
    bmpu_pkg::t_result w_res;
    bmpu_pkg::t_result w_out_res;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_display_mode <= i_cfg_wdata;
        end
    end

    assign w_in_item.data_byte    = s_axis_tdata;
    assign w_in_item.record_start = s_axis_tuser;

    bmpu_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .o_valid (w_st_valid),
        .i_take  (w_fire),
        .o_item  (w_st_item)
    );

    // A held byte is decoded when the result register can take its result
    assign w_fire = w_st_valid && w_out_free;

    bmpu_decoder #(
        .ROW_ALIGN (ROW_ALIGN)
    ) u_decoder (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_display_mode (r_display_mode),
        .i_fire         (w_fire),
        .i_item         (w_st_item),
        .o_res_valid    (w_res_valid),
        .o_res          (w_res)
    );

    bmpu_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire && w_res_valid),
        .i_res   (w_res),
        .i_ready (m_axis_tready),
        .o_free  (w_out_free),
        .o_valid (m_axis_tvalid),
        .o_res   (w_out_res)
    );

    // Output packing
    assign m_axis_tdata = {{(bmpu_pkg::OUT_TDATA_W - 2 * CW - VW){1'b0}},
                           w_out_res.pixel_value, w_out_res.pixel_y, w_out_res.pixel_x};
    assign m_axis_tuser = {w_out_res.is_rgb565, w_out_res.kind};
    assign m_axis_tlast = w_out_res.last_pixel;

endmodule

/* rtl/bmpu_in_stage.sv */
`timescale 1ns / 1ps

// Input register: holds one byte until the decoder takes it
module bmpu_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  bmpu_pkg::t_item  i_item,
    output logic             o_valid,
    input  logic             i_take,
    output bmpu_pkg::t_item  o_item
);

    logic            r_valid;
    bmpu_pkg::t_item r_item;

    // Free when empty or when the held byte leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* rtl/bmpu_decoder.sv */
`timescale 1ns / 1ps

// Header parser and pixel sequencer: one byte per fire, at most one result
module bmpu_decoder #(
    parameter int ROW_ALIGN = bmpu_pkg::ROW_ALIGN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_display_mode,
    input  logic              i_fire,
    input  bmpu_pkg::t_item   i_item,
    output logic              o_res_valid,
    output bmpu_pkg::t_result o_res
);

    localparam int PAD_W = (ROW_ALIGN > 2) ? $clog2(ROW_ALIGN) : 1;
    localparam int CW    = bmpu_pkg::COORD_W;

    typedef enum logic [3:0] {
        PH_IDLE, PH_TYPE, PH_L0, PH_L1, PH_T0, PH_T1,
        PH_W0, PH_W1, PH_H0, PH_H1, PH_PIX, PH_PAD
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [2:0]  r_type,   n_type;
    logic [15:0] r_left,   n_left;
    logic [15:0] r_top,    n_top;
    logic [15:0] r_width,  n_width;
    logic [15:0] r_height, n_height;
    logic [15:0] r_col,    n_col;
    logic [15:0] r_row,    n_row;
    logic [PAD_W-1:0] r_pad, n_pad;
    logic [PAD_W-1:0] r_mod, n_mod;
    logic [7:0]  r_low,    n_low;
    logic        r_hold,   n_hold;

    logic [7:0]       w_b;
    logic [CW-1:0]    w_x;
    logic [CW-1:0]    w_y;
    logic [15:0]      w_col_inc;
    logic [15:0]      w_row_inc;
    logic [PAD_W-1:0] w_mod_inc;
    logic [PAD_W-1:0] w_row_pad;
    logic             w_is_rgb;
    logic             w_type_ok;

    assign w_b       = i_item.data_byte;
    assign w_x       = {1'b0, r_left} + {1'b0, r_col};
    assign w_y       = {1'b0, r_top} + {1'b0, r_height} - CW'(1) - {1'b0, r_row};
    assign w_col_inc = r_col + 16'd1;
    assign w_row_inc = r_row + 16'd1;
    // Column position within the alignment unit, after this byte
    assign w_mod_inc = (r_mod == PAD_W'(ROW_ALIGN - 1)) ? '0 : r_mod + PAD_W'(1);
    assign w_row_pad = (w_mod_inc == '0) ? '0 : PAD_W'(ROW_ALIGN) - w_mod_inc;
    assign w_is_rgb  = (r_type == bmpu_pkg::TYPE_RGB565[2:0]);
    assign w_type_ok = i_display_mode
                     ? (w_b == bmpu_pkg::TYPE_PALETTE || w_b == bmpu_pkg::TYPE_RGB565)
                     : (w_b == bmpu_pkg::TYPE_PLAIN);

    // Next state and result
    always_comb begin
        n_phase  = r_phase;
        n_type   = r_type;
        n_left   = r_left;
        n_top    = r_top;
        n_width  = r_width;
        n_height = r_height;
        n_col    = r_col;
        n_row    = r_row;
        n_pad    = r_pad;
        n_mod    = r_mod;
        n_low    = r_low;
        n_hold   = r_hold;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.kind  = bmpu_pkg::KIND_PIXEL;

        if (i_fire) begin
            if (i_item.record_start) begin
                n_hold = 1'b0;
                n_low  = '0;
                if (w_b != bmpu_pkg::OBJ_ID) begin
                    n_phase     = PH_IDLE;
                    o_res_valid = 1'b1;
                    o_res.kind  = bmpu_pkg::KIND_REJECT;
                end else begin
                    n_phase = PH_TYPE;
                end
            end else begin
                unique case (r_phase)
                    PH_TYPE: begin
                        if (!w_type_ok) begin
                            n_phase     = PH_IDLE;
                            o_res_valid = 1'b1;
                            o_res.kind  = bmpu_pkg::KIND_REJECT;
                        end else begin
                            n_type  = w_b[2:0];
                            n_phase = PH_L0;
                        end
                    end
                    PH_L0: begin n_left[7:0]    = w_b; n_left[15:8] = '0;   n_phase = PH_L1; end
                    PH_L1: begin n_left[15:8]   = w_b;                      n_phase = PH_T0; end
                    PH_T0: begin n_top[7:0]     = w_b; n_top[15:8] = '0;    n_phase = PH_T1; end
                    PH_T1: begin n_top[15:8]    = w_b;                      n_phase = PH_W0; end
                    PH_W0: begin n_width[7:0]   = w_b; n_width[15:8] = '0;  n_phase = PH_W1; end
                    PH_W1: begin n_width[15:8]  = w_b;                      n_phase = PH_H0; end
                    PH_H0: begin n_height[7:0]  = w_b; n_height[15:8] = '0; n_phase = PH_H1; end
                    PH_H1: begin
                        n_height[15:8] = w_b;
                        n_col  = '0;
                        n_row  = '0;
                        n_pad  = '0;
                        n_mod  = '0;
                        n_hold = 1'b0;
                        n_low  = '0;
                        if (r_type == bmpu_pkg::TYPE_PLAIN[2:0] || r_width == '0
                                || {w_b, r_height[7:0]} == 16'd0) begin
                            n_phase     = PH_IDLE;
                            o_res_valid = 1'b1;
                            o_res.kind  = bmpu_pkg::KIND_NO_PIXEL;
                        end else begin
                            n_phase = PH_PIX;
                        end
                    end
                    PH_PAD: begin
                        n_pad = r_pad - PAD_W'(1);
                        if (r_pad == PAD_W'(1)) begin
                            n_phase = PH_PIX;
                        end
                    end
                    PH_PIX: begin
                        if (w_is_rgb && !r_hold) begin
                            // Low byte of an RGB565 word: hold it
                            n_low  = w_b;
                            n_hold = 1'b1;
                        end else begin
                            n_hold = 1'b0;
                            n_low  = '0;
                            o_res_valid       = 1'b1;
                            o_res.kind        = bmpu_pkg::KIND_PIXEL;
                            o_res.pixel_x     = w_x;
                            o_res.pixel_y     = w_y;
                            o_res.pixel_value = w_is_rgb ? {w_b, r_low} : {8'd0, w_b};
                            o_res.is_rgb565   = w_is_rgb;
                            if (w_col_inc >= r_width) begin
                                // End of row
                                n_col = '0;
                                n_mod = '0;
                                n_row = w_row_inc;
                                if (w_row_inc >= r_height) begin
                                    o_res.last_pixel = 1'b1;
                                    n_phase          = PH_IDLE;
                                end else if (r_type == bmpu_pkg::TYPE_PALETTE[2:0]) begin
                                    n_pad = w_row_pad;
                                    if (w_row_pad != '0) begin
                                        n_phase = PH_PAD;
                                    end
                                end
                            end else begin
                                n_col = w_col_inc;
                                n_mod = w_mod_inc;
                            end
                        end
                    end
                    default: begin
                        // Idle: byte ignored
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_type   <= '0;
            r_left   <= '0;
            r_top    <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_pad    <= '0;
            r_mod    <= '0;
            r_low    <= '0;
            r_hold   <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_left   <= n_left;
            r_top    <= n_top;
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
            r_pad    <= n_pad;
            r_mod    <= n_mod;
            r_low    <= n_low;
            r_hold   <= n_hold;
        end
    end

endmodule

/* rtl/bmpu_out_stage.sv */
`timescale 1ns / 1ps

// Result register toward the master side
module bmpu_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  bmpu_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output bmpu_pkg::t_result o_res
);

    logic              r_valid;
    bmpu_pkg::t_result r_res;

    // Can take a new result when empty or when the held one transfers now
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

/* test/bitmap_record_pixel_unpacker_top_tb.sv */
`timescale 1ns / 1ps

module bitmap_record_pixel_unpacker_top_tb;

    localparam int WATCH_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES   = 150;
    localparam int NUM_PHASES    = 7;
    localparam int RA            = bmpu_pkg::ROW_ALIGN_DEF;

    // Header walk of the predictor
    typedef enum {
        HS_IDLE, HS_TYPE, HS_L0, HS_L1, HS_T0, HS_T1,
        HS_W0, HS_W1, HS_H0, HS_H1, HS_PIX, HS_PAD
    } t_hdr_state;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic                   i_cfg_wdata   = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = 8'h00;  // [7:0] data_byte
    logic                   s_axis_tuser  = 1'b0;   // [0] record_start
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [16:0] x, [33:17] y, [49:34] value
    logic [bmpu_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [2:0]             m_axis_tuser;  // [1:0] kind, [2] is_rgb565
    logic                   m_axis_tlast;  // last_pixel

    // Stimulus and expectation stores
    bmpu_pkg::t_item   byte_q[$];
    bmpu_pkg::t_result pix_exp_q[$];
    logic [7:0]        rec_buf[$];
    bmpu_pkg::t_item   drv_cur;
    bmpu_pkg::t_result mon_got;
    bmpu_pkg::t_result mon_want;
    int         bytes_pushed = 0;
    int         bytes_taken  = 0;
    int         err_cnt      = 0;
    int         quiet_cycles = 0;
    logic       calm         = 1'b0;

    // Predictor state
    logic       disp_mode = 1'b0;
    t_hdr_state hs        = HS_IDLE;
    logic [2:0] img_type  = '0;
    logic [15:0] left_e   = '0;
    logic [15:0] top_e    = '0;
    logic [15:0] wid      = '0;
    logic [15:0] hgt      = '0;
    logic [15:0] col      = '0;
    logic [15:0] row      = '0;
    int          pad_cnt  = 0;
    logic [7:0]  hold_lo  = '0;
    logic        holding  = 1'b0;

    bitmap_record_pixel_unpacker_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Decode one accepted byte and queue the pixel write or status it causes
    task automatic decode_byte(input logic [7:0] b, input logic st);
        bmpu_pkg::t_result r;
        logic        emit;
        logic [15:0] v;
        r    = '0;
        emit = 1'b0;
        v    = '0;
        if (st) begin
            hs      = HS_IDLE;
            holding = 1'b0;
            hold_lo = '0;
            if (b != bmpu_pkg::OBJ_ID) begin
                r.kind = bmpu_pkg::KIND_REJECT;
                pix_exp_q.push_back(r);
            end else begin
                hs = HS_TYPE;
            end
        end else begin
            case (hs)
                HS_TYPE: begin
                    if (disp_mode ? (b == bmpu_pkg::TYPE_PALETTE
                                     || b == bmpu_pkg::TYPE_RGB565)
                                  : (b == bmpu_pkg::TYPE_PLAIN)) begin
                        img_type = b[2:0];
                        hs = HS_L0;
                    end else begin
                        hs = HS_IDLE;
                        r.kind = bmpu_pkg::KIND_REJECT;
                        pix_exp_q.push_back(r);
                    end
                end
                HS_L0: begin left_e = {8'h00, b}; hs = HS_L1; end
                HS_L1: begin left_e[15:8] = b;    hs = HS_T0; end
                HS_T0: begin top_e = {8'h00, b};  hs = HS_T1; end
                HS_T1: begin top_e[15:8] = b;     hs = HS_W0; end
                HS_W0: begin wid = {8'h00, b};    hs = HS_W1; end
                HS_W1: begin wid[15:8] = b;       hs = HS_H0; end
                HS_H0: begin hgt = {8'h00, b};    hs = HS_H1; end
                HS_H1: begin
                    hgt[15:8] = b;
                    col     = '0;
                    row     = '0;
                    pad_cnt = 0;
                    holding = 1'b0;
                    hold_lo = '0;
                    if ({5'b0, img_type} == bmpu_pkg::TYPE_PLAIN || wid == 0 || hgt == 0) begin
                        hs = HS_IDLE;
                        r.kind = bmpu_pkg::KIND_NO_PIXEL;
                        pix_exp_q.push_back(r);
                    end else begin
                        hs = HS_PIX;
                    end
                end
                HS_PAD: begin
                    if (pad_cnt > 0) pad_cnt--;
                    if (pad_cnt == 0) hs = HS_PIX;
                end
                HS_PIX: begin
                    // RGB565 words arrive low byte first
                    if ({5'b0, img_type} == bmpu_pkg::TYPE_RGB565) begin
                        if (!holding) begin
                            hold_lo = b;
                            holding = 1'b1;
                        end else begin
                            v       = {b, hold_lo};
                            holding = 1'b0;
                            hold_lo = '0;
                            emit    = 1'b1;
                        end
                    end else begin
                        v    = {8'h00, b};
                        emit = 1'b1;
                    end
                    if (emit) begin
                        r.kind        = bmpu_pkg::KIND_PIXEL;
                        r.pixel_x     = {1'b0, left_e} + {1'b0, col};
                        r.pixel_y     = {1'b0, top_e} + {1'b0, hgt} - 17'd1 - {1'b0, row};
                        r.pixel_value = v;
                        r.is_rgb565   = ({5'b0, img_type} == bmpu_pkg::TYPE_RGB565);
                        col = col + 16'd1;
                        if (col >= wid) begin
                            col = '0;
                            row = row + 16'd1;
                            if (row >= hgt) begin
                                r.last_pixel = 1'b1;
                                hs = HS_IDLE;
                            end else if ({5'b0, img_type} == bmpu_pkg::TYPE_PALETTE) begin
                                pad_cnt = (RA - int'(wid) % RA) % RA;
                                if (pad_cnt != 0) hs = HS_PAD;
                            end
                        end
                        pix_exp_q.push_back(r);
                    end
                end
                default: ;
            endcase
        end
    endtask

    task automatic cmp_field(input string fname, input int unsigned want,
                             input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, fname, want, got);
            err_cnt++;
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic st);
        bmpu_pkg::t_item it;
        it.data_byte    = b;
        it.record_start = st;
        byte_q.push_back(it);
        bytes_pushed++;
    endtask

    // Build a record (header, pixel bytes, row pad) into rec_buf
    task automatic fill_record(input logic [7:0] typ, input logic [15:0] lft,
                               input logic [15:0] tp, input logic [15:0] w,
                               input logic [15:0] h);
        int rowb;
        int nbytes;
        rec_buf.delete();
        rec_buf.push_back(bmpu_pkg::OBJ_ID);
        rec_buf.push_back(typ);
        rec_buf.push_back(lft[7:0]);
        rec_buf.push_back(lft[15:8]);
        rec_buf.push_back(tp[7:0]);
        rec_buf.push_back(tp[15:8]);
        rec_buf.push_back(w[7:0]);
        rec_buf.push_back(w[15:8]);
        rec_buf.push_back(h[7:0]);
        rec_buf.push_back(h[15:8]);
        if (typ == bmpu_pkg::TYPE_RGB565) begin
            rowb = 2 * int'(w);
        end else if (typ == bmpu_pkg::TYPE_PALETTE) begin
            rowb = int'(w) + (RA - int'(w) % RA) % RA;
        end else begin
            rowb = int'(w);
        end
        // huge images only get a few pixels before being abandoned
        if (w > 64 || h > 64) nbytes = 16;
        else nbytes = rowb * int'(h);
        repeat (nbytes) rec_buf.push_back(8'($urandom_range(255)));
    endtask

    task automatic push_rec(input int cnt);
        for (int i = 0; i < cnt && i < rec_buf.size(); i++) begin
            push_byte(rec_buf[i], i == 0);
        end
    endtask

    task automatic add_rand_record();
        int         sel;
        int         cut;
        logic [7:0] typ;
        logic [15:0] w;
        logic [15:0] h;
        sel = $urandom_range(99);
        if (sel < 8) begin
            // line noise
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)),
                                                    $urandom_range(3) == 0);
        end else begin
            if (sel < 16) typ = 8'($urandom_range(255));
            else if (disp_mode) typ = $urandom_range(1) ? bmpu_pkg::TYPE_PALETTE
                                                        : bmpu_pkg::TYPE_RGB565;
            else typ = bmpu_pkg::TYPE_PLAIN;
            w = ($urandom_range(11) == 0) ? 16'd0 : 16'($urandom_range(1, 9));
            h = ($urandom_range(11) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
            fill_record(typ, 16'($urandom_range(65535)), 16'($urandom_range(65535)), w, h);
            if (sel < 20) rec_buf[0] = 8'($urandom_range(255));
            cut = rec_buf.size();
            if (sel >= 20 && sel < 30) cut = $urandom_range(1, rec_buf.size() - 1);
            push_rec(cut);
        end
    endtask

    // Wait until every byte is taken and every result has come, then let
    // the pipeline settle for bytes that cause nothing
    task automatic drain();
        while (bytes_taken != bytes_pushed || pix_exp_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic m);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        disp_mode = m;
    endtask

    // Byte driver: one transfer per handshake, random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(drv_cur.data_byte, drv_cur.record_start);
                bytes_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (byte_q.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
                    drv_cur = byte_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= drv_cur.data_byte;
                    s_axis_tuser  <= drv_cur.record_start;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                mon_got.kind        = bmpu_pkg::t_kind'(m_axis_tuser[1:0]);
                mon_got.pixel_x     = m_axis_tdata[16:0];
                mon_got.pixel_y     = m_axis_tdata[33:17];
                mon_got.pixel_value = m_axis_tdata[49:34];
                mon_got.is_rgb565   = m_axis_tuser[2];
                mon_got.last_pixel  = m_axis_tlast;
                if (pix_exp_q.size() == 0) begin
                    $display("%0t: extra result, expected none, actual kind %0d x %0h y %0h v %0h",
                             $time, mon_got.kind, mon_got.pixel_x, mon_got.pixel_y,
                             mon_got.pixel_value);
                    err_cnt++;
                end else begin
                    mon_want = pix_exp_q.pop_front();
                    cmp_field("kind", mon_want.kind, mon_got.kind);
                    cmp_field("pixel_x", mon_want.pixel_x, mon_got.pixel_x);
                    cmp_field("pixel_y", mon_want.pixel_y, mon_got.pixel_y);
                    cmp_field("pixel_value", mon_want.pixel_value, mon_got.pixel_value);
                    cmp_field("is_rgb565", mon_want.is_rgb565, mon_got.is_rgb565);
                    cmp_field("last_pixel", mon_want.last_pixel, mon_got.last_pixel);
                end
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 19);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("%0t: watchdog timeout, %0d results still expected",
                     $time, pix_exp_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int phase_base;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: mode 0, bad ids, idle bytes, type tests, abandoned header
        set_mode(1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hA5, 1'b0);
        fill_record(bmpu_pkg::TYPE_PLAIN, 16'h0001, 16'h0002, 16'd3, 16'd2);
        push_rec(rec_buf.size());
        fill_record(bmpu_pkg::TYPE_PALETTE, 16'h0010, 16'h0020, 16'd2, 16'd2);
        push_rec(rec_buf.size());
        fill_record(bmpu_pkg::TYPE_PLAIN, 16'h0000, 16'h0000, 16'd1, 16'd1);
        push_rec(5);
        fill_record(bmpu_pkg::TYPE_PLAIN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_rec(rec_buf.size());
        drain();

        // Directed: mode 1, padded palette rows, RGB565, empty images,
        // restart in the middle of pixel data and of a held low byte
        set_mode(1'b1);
        fill_record(bmpu_pkg::TYPE_PALETTE, 16'hFFFF, 16'hFFFF, 16'd5, 16'd2);
        push_rec(rec_buf.size());
        fill_record(bmpu_pkg::TYPE_RGB565, 16'h0000, 16'h0000, 16'd2, 16'd2);
        push_rec(rec_buf.size());
        fill_record(bmpu_pkg::TYPE_PLAIN, 16'h0003, 16'h0004, 16'd1, 16'd1);
        push_rec(rec_buf.size());
        fill_record(8'd3, 16'h0003, 16'h0004, 16'd1, 16'd1);
        push_rec(rec_buf.size());
        fill_record(bmpu_pkg::TYPE_PALETTE, 16'h0007, 16'h0009, 16'd0, 16'd3);
        push_rec(rec_buf.size());
        fill_record(bmpu_pkg::TYPE_RGB565, 16'h0007, 16'h0009, 16'd4, 16'd0);
        push_rec(rec_buf.size());
        fill_record(bmpu_pkg::TYPE_RGB565, 16'h1234, 16'h8000, 16'hFFFF, 16'hFFFF);
        push_rec(15);
        fill_record(bmpu_pkg::TYPE_PALETTE, 16'h8000, 16'h1234, 16'hFFFF, 16'hFFFF);
        push_rec(13);
        fill_record(bmpu_pkg::TYPE_RGB565, 16'h00FF, 16'hFF00, 16'd3, 16'd1);
        push_rec(rec_buf.size());
        drain();

        // Random phases, mode changed only between them
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            calm = (ph == 3);
            set_mode(ph % 3 != 1);
            phase_base = bytes_pushed;
            while (bytes_pushed - phase_base < PHASE_BYTES) add_rand_record();
            drain();
        end
        calm = 1'b0;

        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/bmpu_pkg.sv
rtl/bmpu_in_stage.sv
rtl/bmpu_decoder.sv
rtl/bmpu_out_stage.sv
rtl/bitmap_record_pixel_unpacker_top.sv
test/bitmap_record_pixel_unpacker_top_tb.sv
